// ----- hdl/smeu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the stack machine execute unit.
// No dependencies; every other file refers to this package by scoped names.
package smeu_pkg;

    localparam int PC_W   = 11;
    localparam int DATA_W = 32;

    // Instruction opcodes
    localparam logic [3:0] OP_PUSHIMM = 4'd0;
    localparam logic [3:0] OP_PUSHVAR = 4'd1;
    localparam logic [3:0] OP_POPVAR  = 4'd2;
    localparam logic [3:0] OP_ADD     = 4'd3;
    localparam logic [3:0] OP_SUB     = 4'd4;
    localparam logic [3:0] OP_MUL     = 4'd5;
    localparam logic [3:0] OP_DIV     = 4'd6;
    localparam logic [3:0] OP_MOD     = 4'd7;
    localparam logic [3:0] OP_READ    = 4'd8;
    localparam logic [3:0] OP_WRITE   = 4'd9;
    localparam logic [3:0] OP_JMP     = 4'd10;
    localparam logic [3:0] OP_JI      = 4'd11;
    localparam logic [3:0] OP_END     = 4'd12;

    // Status codes
    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_UNDER  = 4'd1;
    localparam logic [3:0] ST_OVER   = 4'd2;
    localparam logic [3:0] ST_UNKVAR = 4'd3;
    localparam logic [3:0] ST_DIVZ   = 4'd4;
    localparam logic [3:0] ST_NOTNAT = 4'd5;
    localparam logic [3:0] ST_JBOUND = 4'd6;
    localparam logic [3:0] ST_BADOP  = 4'd7;
    localparam logic [3:0] ST_HALTED = 4'd8;

    typedef struct packed {
        logic [3:0]               req_type;
        logic signed [DATA_W-1:0] operand_value;
        logic [3:0]               var_index;
        logic signed [DATA_W-1:0] jump_target;
    } req_t;

    typedef struct packed {
        logic [3:0]               status;
        logic                     write_valid;
        logic signed [DATA_W-1:0] write_value;
        logic [PC_W-1:0]          next_pc;
        logic                     halted;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic want_mod;
    } div_ctl_t;

endpackage

// ----- hdl/smeu_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction and result words.
// Depends on smeu_pkg for the payload types.
interface smeu_req_if;
    logic          valid;
    logic          ready;
    smeu_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smeu_rsp_if;
    logic          valid;
    logic          ready;
    smeu_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/stack_machine_execute_unit_top.sv -----
`timescale 1ns / 1ps
// Top level of the stack machine execute unit: sequencer, state and result register.
// Depends on smeu_pkg, smeu_if, smeu_stack and smeu_divider.
//
// The unit executes one decoded stack-machine instruction per request word and
// returns one result word per instruction: status, written value, next pc and the
// halt flag. It takes one word at a time. Most instructions pass through operand
// read, execute and write back; divide and modulo wait between execute and write
// back on the shared divider, which retires one quotient bit per cycle. A new
// request is accepted while the previous result still waits on the result channel.
// program_length must be written through cfg_wr_en/cfg_wr_data while the unit is
// idle; this is not enforced. Values above MAX_PROGRAM act as MAX_PROGRAM. Any
// error halts the machine; once halted, every request returns status HALTED with
// the pc held. The operand stack and variable store need no clearing after reset.
module stack_machine_execute_unit_top
#(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 16,
    parameter int MAX_PROGRAM = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [smeu_pkg::PC_W-1:0] cfg_wr_data,
    smeu_req_if.sink                  req,
    smeu_rsp_if.source                rsp
);
    localparam int W   = smeu_pkg::DATA_W;
    localparam int PW  = smeu_pkg::PC_W;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_WB   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Architectural state
    logic [SCW-1:0]       cnt_reg;
    logic [PW-1:0]        pc_reg;
    logic                 halt_reg;
    logic [PW-1:0]        plen_reg;
    logic [VAR_COUNT-1:0] var_valid_reg;
    logic [W-1:0]         var_mem [VAR_COUNT];
    logic [W-1:0]         var_rd;

    // Latched request and working result
    logic [3:0]   op_reg;
    logic [W-1:0] val_reg;
    logic [3:0]   vi_reg;
    logic [W-1:0] tgt_reg;
    logic [W-1:0] res_reg;

    smeu_pkg::rsp_t rsp_reg;
    logic           rsp_valid_reg;

    // Stack port wiring
    logic [W-1:0]   top, sec;
    logic           stk_we;
    logic [SAW-1:0] stk_waddr;
    logic [W-1:0]   stk_wdata;
    logic [SCW-1:0] cnt_m1, cnt_m2;

    smeu_pkg::div_ctl_t div_ctl;
    logic               div_done;
    logic [W-1:0]       div_res;

    // Decode results
    logic [PW-1:0]  len_eff;
    logic           skip, full, empty, in_var, var_ok, jump_bad;
    logic [VAW-1:0] va;
    logic [3:0]     st;
    logic           wv, stop, push, pop, fold, vwr;
    logic [W-1:0]   wval, push_data;
    logic [PW-1:0]  npc;
    logic           fire;
    smeu_pkg::rsp_t rsp_new;

    assign cnt_m1 = cnt_reg - SCW'(1);
    assign cnt_m2 = cnt_reg - SCW'(2);

    smeu_stack #(.DEPTH(STACK_DEPTH)) u_stack (
        .clk       (clk),
        .rd_addr_a (cnt_m1[SAW-1:0]),
        .rd_addr_b (cnt_m2[SAW-1:0]),
        .rd_data_a (top),
        .rd_data_b (sec),
        .wr_en     (stk_we),
        .wr_addr   (stk_waddr),
        .wr_data   (stk_wdata)
    );

    smeu_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (sec),
        .divisor  (top),
        .done     (div_done),
        .result   (div_res)
    );

    // Clamp the program length to what the unit supports
    assign len_eff = (32'(plen_reg) > 32'(MAX_PROGRAM)) ? PW'(MAX_PROGRAM) : plen_reg;

    assign va       = VAW'(vi_reg);
    assign skip     = halt_reg || (pc_reg >= len_eff);
    assign full     = (cnt_reg == SCW'(STACK_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign in_var   = (32'(vi_reg) < 32'(VAR_COUNT));
    assign var_ok   = in_var && var_valid_reg[va];
    assign jump_bad = tgt_reg[W-1] || (tgt_reg >= 32'(len_eff));

    // Instruction decode; evaluated in write back with stable operands
    always_comb
    begin
        st        = smeu_pkg::ST_OK;
        wv        = 1'b0;
        wval      = '0;
        npc       = pc_reg + PW'(1);
        stop      = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        fold      = 1'b0;
        vwr       = 1'b0;
        push_data = val_reg;
        case (op_reg)
            smeu_pkg::OP_PUSHIMM:
            begin
                if (full) st = smeu_pkg::ST_OVER;
                else push = 1'b1;
            end
            smeu_pkg::OP_PUSHVAR:
            begin
                push_data = var_rd;
                if (!var_ok) st = smeu_pkg::ST_UNKVAR;
                else if (full) st = smeu_pkg::ST_OVER;
                else push = 1'b1;
            end
            smeu_pkg::OP_POPVAR:
            begin
                if (empty) st = smeu_pkg::ST_UNDER;
                else
                begin
                    pop = 1'b1;
                    vwr = in_var;
                end
            end
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
            smeu_pkg::OP_DIV, smeu_pkg::OP_MOD:
            begin
                if (cnt_reg < SCW'(2)) st = smeu_pkg::ST_UNDER;
                else if ((op_reg == smeu_pkg::OP_DIV || op_reg == smeu_pkg::OP_MOD)
                         && top == '0) st = smeu_pkg::ST_DIVZ;
                else fold = 1'b1;
            end
            smeu_pkg::OP_READ:
            begin
                if (val_reg == '0 || val_reg[W-1]) st = smeu_pkg::ST_NOTNAT;
                else if (full) st = smeu_pkg::ST_OVER;
                else push = 1'b1;
            end
            smeu_pkg::OP_WRITE:
            begin
                if (empty) st = smeu_pkg::ST_UNDER;
                else
                begin
                    pop  = 1'b1;
                    wv   = 1'b1;
                    wval = top;
                end
            end
            smeu_pkg::OP_JMP:
            begin
                if (jump_bad) st = smeu_pkg::ST_JBOUND;
                else npc = tgt_reg[PW-1:0];
            end
            smeu_pkg::OP_JI:
            begin
                if (empty) st = smeu_pkg::ST_UNDER;
                else if (top != '0)
                begin
                    if (jump_bad) st = smeu_pkg::ST_JBOUND;
                    else npc = tgt_reg[PW-1:0];
                end
            end
            smeu_pkg::OP_END:
            begin
                stop = 1'b1;
            end
            default:
            begin
                st = smeu_pkg::ST_BADOP;
            end
        endcase
        if (st != smeu_pkg::ST_OK || npc >= len_eff) stop = 1'b1;

        if (skip)
        begin
            rsp_new.status      = smeu_pkg::ST_HALTED;
            rsp_new.write_valid = 1'b0;
            rsp_new.write_value = '0;
            rsp_new.next_pc     = pc_reg;
            rsp_new.halted      = 1'b1;
        end
        else
        begin
            rsp_new.status      = st;
            rsp_new.write_valid = wv;
            rsp_new.write_value = wval;
            rsp_new.next_pc     = npc;
            rsp_new.halted      = halt_reg || stop;
        end
    end

    // Write back only when the result register can take the new word
    assign fire = (state_reg == S_WB) && (!rsp_valid_reg || rsp.ready);

    // Stack write port: push at the count, fold into the second entry
    always_comb
    begin
        stk_we    = fire && !skip && (push || fold);
        stk_waddr = fold ? cnt_m2[SAW-1:0] : cnt_reg[SAW-1:0];
        stk_wdata = fold ? res_reg : push_data;
    end

    always_comb
    begin
        div_ctl.start    = (state_reg == S_EXEC) && !skip
                           && (op_reg == smeu_pkg::OP_DIV || op_reg == smeu_pkg::OP_MOD)
                           && (cnt_reg >= SCW'(2)) && (top != '0);
        div_ctl.want_mod = (op_reg == smeu_pkg::OP_MOD);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req.valid) state_next = S_EXEC;
            S_EXEC: state_next = div_ctl.start ? S_DIV : S_WB;
            S_DIV:  if (div_done) state_next = S_WB;
            S_WB:   if (fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            plen_reg      <= '0;
            var_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en) plen_reg <= cfg_wr_data;
            if (fire) rsp_valid_reg <= 1'b1;
            else if (rsp.ready) rsp_valid_reg <= 1'b0;
            if (fire)
            begin
                halt_reg      <= rsp_new.halted;
                if (!skip)
                begin
                    pc_reg <= npc;
                    if (push) cnt_reg <= cnt_reg + SCW'(1);
                    else if (pop || fold) cnt_reg <= cnt_m1;
                    if (vwr) var_valid_reg[va] <= 1'b1;
                end
            end
        end
    end

    // Payload: latched request, arithmetic result, result word
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= req.data.req_type;
            val_reg <= req.data.operand_value;
            vi_reg  <= req.data.var_index;
            tgt_reg <= req.data.jump_target;
        end
        if (state_reg == S_EXEC)
        begin
            case (op_reg)
                smeu_pkg::OP_ADD: res_reg <= sec + top;
                smeu_pkg::OP_SUB: res_reg <= sec - top;
                default:          res_reg <= W'(sec * top);
            endcase
        end
        else if (div_done)
        begin
            res_reg <= div_res;
        end
        if (fire) rsp_reg <= rsp_new;
    end

    // Variable store: read at the incoming index while idle, write on pop
    always_ff @(posedge clk)
    begin
        if (fire && !skip && vwr) var_mem[va] <= top;
        var_rd <= var_mem[(state_reg == S_IDLE) ? VAW'(req.data.var_index) : va];
    end

endmodule

// ----- hdl/smeu_divider.sv -----
`timescale 1ns / 1ps
// Signed truncating divide/modulo, one quotient bit per cycle (restoring).
// Depends on smeu_pkg for the data width and control struct.
module smeu_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  smeu_pkg::div_ctl_t        ctl,
    input  logic [smeu_pkg::DATA_W-1:0] dividend,
    input  logic [smeu_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [smeu_pkg::DATA_W-1:0] result
);
    localparam int W  = smeu_pkg::DATA_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg;
    logic          na_reg, nb_reg, mod_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;
    logic [W-1:0]  fix_q, fix_r;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};
        rem_next = trial[W] ? {rem_reg[W-2:0], quo_reg[W-1]} : trial[W-1:0];
        quo_next = {quo_reg[W-2:0], ~trial[W]};
        cnt_next = cnt_reg + CW'(1);
        busy_next = busy_reg && (cnt_next != CW'(W));
        fix_q = (na_reg ^ nb_reg) ? (W'(0) - quo_reg) : quo_reg;
        fix_r = na_reg ? (W'(0) - rem_reg) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
                done     <= !busy_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            // work on magnitudes, fix the signs at the end
            na_reg  <= dividend[W-1];
            nb_reg  <= divisor[W-1];
            mod_reg <= ctl.want_mod;
            rem_reg <= '0;
            quo_reg <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            den_reg <= divisor[W-1] ? (W'(0) - divisor) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign result = mod_reg ? fix_r : fix_q;

endmodule

// ----- hdl/smeu_stack.sv -----
`timescale 1ns / 1ps
// Operand stack memory: one write port, two registered read ports.
// Depends on smeu_pkg for the data width.
module smeu_stack
#(
    parameter int DEPTH = 64
)
(
    input  logic                        clk,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr_b,
    output logic [smeu_pkg::DATA_W-1:0] rd_data_a,
    output logic [smeu_pkg::DATA_W-1:0] rd_data_b,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [smeu_pkg::DATA_W-1:0] wr_data
);
    logic [smeu_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
